>>> rtl/core/ktgc_pkg.sv
// Package for the keypad touch gesture classifier: request/response types,
// gesture codes, register indexes, history sizing and the scroll path table.
// No dependencies.
package ktgc_pkg;

   // History ring sizing.
   localparam int HIST_DEPTH = 10;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int HIST_CW    = $clog2(HIST_DEPTH + 1);

   // Gesture codes as reported on the response channel.
   localparam logic [3:0] GEST_NONE       = 4'd0;
   localparam logic [3:0] GEST_TAP        = 4'd1;
   localparam logic [3:0] GEST_DOUBLE     = 4'd2;
   localparam logic [3:0] GEST_LONG       = 4'd3;
   localparam logic [3:0] GEST_UP         = 4'd4;
   localparam logic [3:0] GEST_DOWN       = 4'd5;
   localparam logic [3:0] GEST_LEFT       = 4'd6;
   localparam logic [3:0] GEST_RIGHT      = 4'd7;
   localparam logic [3:0] GEST_CW         = 4'd8;
   localparam logic [3:0] GEST_CCW        = 4'd9;
   localparam logic [3:0] GEST_TWO_FINGER = 4'd10;

   // Configuration register indexes.
   localparam logic [2:0] CSR_TAP_MAX    = 3'd0;
   localparam logic [2:0] CSR_LONG_MIN   = 3'd1;
   localparam logic [2:0] CSR_DTAP_GAP   = 3'd2;
   localparam logic [2:0] CSR_SWIPE_MIN  = 3'd3;
   localparam logic [2:0] CSR_SCROLL_MIN = 3'd4;

   // Register reset values.
   localparam logic [15:0] TAP_MAX_RST    = 16'd200;
   localparam logic [15:0] LONG_MIN_RST   = 16'd500;
   localparam logic [15:0] DTAP_GAP_RST   = 16'd300;
   localparam logic [4:0]  SWIPE_MIN_RST  = 5'd2;
   localparam logic [4:0]  SCROLL_MIN_RST = 5'd3;

   // Six 4-key scroll paths; a forward match is clockwise.
   localparam int NUM_PATHS = 6;
   localparam logic [4:0] SCROLL_PATHS [0:NUM_PATHS-1][0:3] = '{
      '{5'd1,  5'd2,  5'd3,  5'd4},
      '{5'd4,  5'd8,  5'd12, 5'd16},
      '{5'd16, 5'd15, 5'd14, 5'd13},
      '{5'd13, 5'd9,  5'd5,  5'd1},
      '{5'd2,  5'd6,  5'd10, 5'd14},
      '{5'd5,  5'd6,  5'd7,  5'd8}
   };

   typedef struct packed {
      logic [15:0] touch_bits;
      logic [31:0] time_ms;
   } req_type;

   typedef struct packed {
      logic [3:0] gesture_code;
      logic       touch_active;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

endpackage

>>> rtl/core/keypad_touch_gesture_classifier_core.sv
// Keypad touch gesture classifier, top level: sample handling, history memory
// with read scan on release, and gesture classification.
// Depends on ktgc_pkg.
//
//   Channel  Ports                         Direction  Moves
//   req      req_valid/req_ready/req_data  in         one pad sample per request
//   rsp      rsp_valid/rsp_ready/rsp_data  out        one gesture result per request
//   csr      csr_we/csr_index/csr_wdata    in         register write, no wait
//
// A request that is not a release produces its response on the next cycle.
// A release request scans the whole history: the history memory is read one
// entry per cycle, a final scan step drains the last read, and ST_DECIDE
// classifies and loads the output register once that register is free.
// Reset is synchronous and active high; it clears all control state and the
// per-entry valid bits of the history, so the memory itself needs no sweep.
// The output register parts both sides: a new request is taken while a response
// still waits, as long as the block is idle and the output register frees up.
module keypad_touch_gesture_classifier_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ktgc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ktgc_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   // Configuration registers.
   logic [15:0] tap_max_ff,    tap_max_in;
   logic [15:0] long_min_ff,   long_min_in;
   logic [15:0] dtap_gap_ff,   dtap_gap_in;
   logic [4:0]  swipe_min_ff,  swipe_min_in;
   logic [4:0]  scroll_min_ff, scroll_min_in;

   // Touch tracking state.
   ktgc_pkg::state_type          state_ff, state_in;
   logic [ktgc_pkg::HIST_AW-1:0] wp_ff, wp_in;
   logic [15:0]                  prev_bits_ff, prev_bits_in;
   logic [31:0]                  press_start_ff, press_start_in;
   logic [31:0]                  prev_tap_ff, prev_tap_in;
   logic [4:0]                   prev_key_ff, prev_key_in;

   // History memory: data in a synchronous RAM, valid bits in flops so that a
   // release or a reset empties the ring by clearing them all together.
   logic [4:0]                      hist_mem [ktgc_pkg::HIST_DEPTH];
   logic [ktgc_pkg::HIST_DEPTH-1:0] hist_vld_ff, hist_vld_in;
   logic                            hist_we;
   logic [ktgc_pkg::HIST_AW-1:0]    hist_waddr;
   logic [4:0]                      hist_wdata;
   logic                            rd_en;
   logic [ktgc_pkg::HIST_AW-1:0]    rd_addr;
   logic [4:0]                      rd_data_ff;
   logic                            rd_vld_ff;

   // Scan counters and accumulators for the release classification.
   logic [ktgc_pkg::HIST_CW-1:0] cnt_ff, cnt_in;
   logic                         rd_pend_ff, rd_pend_in;
   logic [31:0]                  now_ff, now_in;
   logic [31:0]                  hold_ff, hold_in;
   logic                         two_ff, two_in;
   logic [15:0]                  seen_ff, seen_in;
   logic [ktgc_pkg::HIST_CW-1:0] n_ff, n_in;
   logic [4:0]                   k0_ff, k0_in, k1_ff, k1_in, k2_ff, k2_in;
   logic [4:0]                   first_ff, first_in, last_ff, last_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   ktgc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic              out_free;
   logic              req_acc;
   logic [4:0]        low_key;
   logic [4:0]        scan_key;
   logic [4:0]        scan_km1;
   logic [4:0]        uniq;
   logic [1:0]        cmp_len;
   logic [ktgc_pkg::HIST_CW-1:0] n_m1;
   logic [3:0]        scroll_code;
   logic [3:0]        swipe_code;
   logic [3:0]        gest_code;
   logic [2:0]        dr, dc;
   logic [1:0]        ar, ac;
   logic [4:0]        f_m1, l_m1;
   logic              path_cw  [ktgc_pkg::NUM_PATHS];
   logic              path_ccw [ktgc_pkg::NUM_PATHS];
   logic [4:0]        keys [3];
   logic              hold_lt_tap;
   logic              is_double;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ktgc_pkg::ST_IDLE) && out_free;
   assign req_acc   = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Lowest touched key, 1..16, or 0 when nothing is touched.
   always_comb begin
      low_key = 5'd0;
      for (int i = 15; i >= 0; i--) begin
         if (req_data.touch_bits[i]) begin
            low_key = 5'(i + 1);
         end
      end
   end

   // Entry delivered by the memory this cycle; an entry never written reads empty.
   assign scan_key = rd_vld_ff ? rd_data_ff : 5'd0;
   assign scan_km1 = scan_key - 5'd1;

   // Classification from the scan results.
   always_comb begin
      uniq = 5'd0;
      for (int i = 0; i < 16; i++) begin
         uniq = uniq + 5'(seen_ff[i]);
      end

      // Number of leading compacted keys compared against each path.
      n_m1 = n_ff - 1'b1;
      if (n_ff == '0) begin
         cmp_len = 2'd0;
      end else if (n_m1 > ktgc_pkg::HIST_CW'(3)) begin
         cmp_len = 2'd3;
      end else begin
         cmp_len = n_m1[1:0];
      end

      keys[0] = k0_ff;
      keys[1] = k1_ff;
      keys[2] = k2_ff;
      for (int p = 0; p < ktgc_pkg::NUM_PATHS; p++) begin
         path_cw[p]  = 1'b1;
         path_ccw[p] = 1'b1;
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < cmp_len) begin
               if (keys[i] != ktgc_pkg::SCROLL_PATHS[p][i]) begin
                  path_cw[p] = 1'b0;
               end
               if (keys[i] != ktgc_pkg::SCROLL_PATHS[p][3-i]) begin
                  path_ccw[p] = 1'b0;
               end
            end
         end
      end

      // Paths are tried in table order, clockwise before counter-clockwise.
      scroll_code = ktgc_pkg::GEST_NONE;
      if (5'(n_ff) >= scroll_min_ff) begin
         for (int p = ktgc_pkg::NUM_PATHS - 1; p >= 0; p--) begin
            if (path_cw[p]) begin
               scroll_code = ktgc_pkg::GEST_CW;
            end else if (path_ccw[p]) begin
               scroll_code = ktgc_pkg::GEST_CCW;
            end
         end
      end

      // Swipe from the first and last nonempty entries in address order.
      f_m1 = first_ff - 5'd1;
      l_m1 = last_ff - 5'd1;
      dr   = {1'b0, l_m1[3:2]} - {1'b0, f_m1[3:2]};
      dc   = {1'b0, l_m1[1:0]} - {1'b0, f_m1[1:0]};
      ar   = dr[2] ? 2'(-dr) : dr[1:0];
      ac   = dc[2] ? 2'(-dc) : dc[1:0];
      if (first_ff == 5'd0) begin
         swipe_code = ktgc_pkg::GEST_NONE;
      end else if (ar > ac) begin
         swipe_code = dr[2] ? ktgc_pkg::GEST_UP : ktgc_pkg::GEST_DOWN;
      end else if (ac > ar) begin
         swipe_code = dc[2] ? ktgc_pkg::GEST_LEFT : ktgc_pkg::GEST_RIGHT;
      end else begin
         swipe_code = ktgc_pkg::GEST_NONE;
      end

      hold_lt_tap = hold_ff < {16'd0, tap_max_ff};
      is_double   = (now_ff - prev_tap_ff) < {16'd0, dtap_gap_ff};

      if (two_ff && hold_lt_tap) begin
         gest_code = ktgc_pkg::GEST_TWO_FINGER;
      end else if ((hold_ff >= {16'd0, long_min_ff}) && (uniq == 5'd1)) begin
         gest_code = ktgc_pkg::GEST_LONG;
      end else if (hold_lt_tap && (uniq <= 5'd2)) begin
         gest_code = is_double ? ktgc_pkg::GEST_DOUBLE : ktgc_pkg::GEST_TAP;
      end else if (uniq >= swipe_min_ff) begin
         gest_code = (scroll_code != ktgc_pkg::GEST_NONE) ? scroll_code : swipe_code;
      end else begin
         gest_code = ktgc_pkg::GEST_NONE;
      end
   end

   // Next state for the controller, the tracking registers and the output.
   always_comb begin
      state_in       = state_ff;
      wp_in          = wp_ff;
      prev_bits_in   = prev_bits_ff;
      press_start_in = press_start_ff;
      prev_tap_in    = prev_tap_ff;
      prev_key_in    = prev_key_ff;
      hist_vld_in    = hist_vld_ff;
      cnt_in         = cnt_ff;
      rd_pend_in     = 1'b0;
      now_in         = now_ff;
      hold_in        = hold_ff;
      two_in         = two_ff;
      seen_in        = seen_ff;
      n_in           = n_ff;
      k0_in          = k0_ff;
      k1_in          = k1_ff;
      k2_in          = k2_ff;
      first_in       = first_ff;
      last_in        = last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      hist_we        = 1'b0;
      hist_waddr     = wp_ff;
      hist_wdata     = low_key;
      rd_en          = 1'b0;
      rd_addr        = cnt_ff[ktgc_pkg::HIST_AW-1:0];

      tap_max_in    = tap_max_ff;
      long_min_in   = long_min_ff;
      dtap_gap_in   = dtap_gap_ff;
      swipe_min_in  = swipe_min_ff;
      scroll_min_in = scroll_min_ff;
      if (csr_we) begin
         unique case (csr_index)
            ktgc_pkg::CSR_TAP_MAX:    tap_max_in    = csr_wdata;
            ktgc_pkg::CSR_LONG_MIN:   long_min_in   = csr_wdata;
            ktgc_pkg::CSR_DTAP_GAP:   dtap_gap_in   = csr_wdata;
            ktgc_pkg::CSR_SWIPE_MIN:  swipe_min_in  = csr_wdata[4:0];
            ktgc_pkg::CSR_SCROLL_MIN: scroll_min_in = csr_wdata[4:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ktgc_pkg::ST_IDLE: begin
            if (req_acc) begin
               prev_bits_in = req_data.touch_bits;
               if ((req_data.touch_bits == 16'd0) && (prev_bits_ff != 16'd0)) begin
                  // Release: capture timing and start the history scan.
                  now_in   = req_data.time_ms;
                  hold_in  = req_data.time_ms - press_start_ff;
                  two_in   = (prev_bits_ff & (prev_bits_ff - 16'd1)) != 16'd0;
                  seen_in  = 16'd0;
                  n_in     = '0;
                  first_in = 5'd0;
                  last_in  = 5'd0;
                  cnt_in   = '0;
                  state_in = ktgc_pkg::ST_SCAN;
               end else begin
                  if ((req_data.touch_bits != 16'd0) && (prev_bits_ff == 16'd0)) begin
                     // Touch-down records the lowest key once.
                     press_start_in = req_data.time_ms;
                     hist_we        = 1'b1;
                     prev_key_in    = low_key;
                  end else if ((req_data.touch_bits != 16'd0)
                               && (req_data.touch_bits != prev_bits_ff)
                               && (low_key != prev_key_ff)) begin
                     hist_we     = 1'b1;
                     prev_key_in = low_key;
                  end
                  if (hist_we) begin
                     hist_vld_in[wp_ff] = 1'b1;
                     wp_in = (wp_ff == ktgc_pkg::HIST_AW'(ktgc_pkg::HIST_DEPTH - 1))
                             ? '0 : wp_ff + 1'b1;
                  end
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.gesture_code = ktgc_pkg::GEST_NONE;
                  rsp_data_in.touch_active = req_data.touch_bits != 16'd0;
               end
            end
         end

         ktgc_pkg::ST_SCAN: begin
            if (cnt_ff != ktgc_pkg::HIST_CW'(ktgc_pkg::HIST_DEPTH)) begin
               rd_en      = 1'b1;
               rd_pend_in = 1'b1;
               cnt_in     = cnt_ff + 1'b1;
            end else begin
               state_in = ktgc_pkg::ST_DECIDE;
            end
            if (rd_pend_ff && (scan_key != 5'd0)) begin
               seen_in[scan_km1[3:0]] = 1'b1;
               case (n_ff)
                  ktgc_pkg::HIST_CW'(0): k0_in = scan_key;
                  ktgc_pkg::HIST_CW'(1): k1_in = scan_key;
                  ktgc_pkg::HIST_CW'(2): k2_in = scan_key;
                  default: ;
               endcase
               n_in = n_ff + 1'b1;
               if (first_ff == 5'd0) begin
                  first_in = scan_key;
               end
               last_in = scan_key;
            end
         end

         ktgc_pkg::ST_DECIDE: begin
            if (out_free) begin
               if (gest_code == ktgc_pkg::GEST_DOUBLE) begin
                  prev_tap_in = 32'd0;
               end else if (gest_code == ktgc_pkg::GEST_TAP) begin
                  prev_tap_in = now_ff;
               end
               rsp_valid_in             = 1'b1;
               rsp_data_in.gesture_code = gest_code;
               rsp_data_in.touch_active = 1'b0;
               hist_vld_in              = '0;
               wp_in                    = '0;
               state_in                 = ktgc_pkg::ST_IDLE;
            end
         end

         default: state_in = ktgc_pkg::ST_IDLE;
      endcase
   end

   // History memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= hist_mem[rd_addr];
         rd_vld_ff  <= hist_vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ktgc_pkg::ST_IDLE;
         wp_ff          <= '0;
         prev_bits_ff   <= 16'd0;
         press_start_ff <= 32'd0;
         prev_tap_ff    <= 32'd0;
         prev_key_ff    <= 5'd0;
         hist_vld_ff    <= '0;
         cnt_ff         <= '0;
         rd_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         tap_max_ff     <= ktgc_pkg::TAP_MAX_RST;
         long_min_ff    <= ktgc_pkg::LONG_MIN_RST;
         dtap_gap_ff    <= ktgc_pkg::DTAP_GAP_RST;
         swipe_min_ff   <= ktgc_pkg::SWIPE_MIN_RST;
         scroll_min_ff  <= ktgc_pkg::SCROLL_MIN_RST;
      end else begin
         state_ff       <= state_in;
         wp_ff          <= wp_in;
         prev_bits_ff   <= prev_bits_in;
         press_start_ff <= press_start_in;
         prev_tap_ff    <= prev_tap_in;
         prev_key_ff    <= prev_key_in;
         hist_vld_ff    <= hist_vld_in;
         cnt_ff         <= cnt_in;
         rd_pend_ff     <= rd_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
         tap_max_ff     <= tap_max_in;
         long_min_ff    <= long_min_in;
         dtap_gap_ff    <= dtap_gap_in;
         swipe_min_ff   <= swipe_min_in;
         scroll_min_ff  <= scroll_min_in;
      end
   end

   // Payload and scan registers carry no reset.
   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      hold_ff     <= hold_in;
      two_ff      <= two_in;
      seen_ff     <= seen_in;
      n_ff        <= n_in;
      k0_ff       <= k0_in;
      k1_ff       <= k1_in;
      k2_ff       <= k2_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> rtl/core/ktgc_checker.sv
// Port-level checker for the keypad touch gesture classifier and its bind.
// Depends on ktgc_pkg and keypad_touch_gesture_classifier_core.
module ktgc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input ktgc_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ktgc_pkg::rsp_type rsp_data
);

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Reset leaves no response pending.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

   // Gestures are reported only on a release.
   a_gest_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.gesture_code != ktgc_pkg::GEST_NONE) |-> !rsp_data.touch_active)
      else $error("gesture reported while touched");

   // A touched sample answers on the next cycle as active.
   a_touch_next: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.touch_bits != 16'd0)
      |=> rsp_valid && rsp_data.touch_active)
      else $error("touched sample did not answer next cycle");

   // Codes above two-finger tap never appear.
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.gesture_code <= ktgc_pkg::GEST_TWO_FINGER)
      else $error("gesture code out of range");

endmodule

bind keypad_touch_gesture_classifier_core ktgc_checker u_ktgc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
